// ----- hdl/sha256_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// types and constants shared by the sha-256 controller and datapath
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_LEN,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		LD_NONE,
		LD_BYTE,
		LD_PAD80,
		LD_LENGTH
	} load_t;

	// controller to datapath
	typedef struct packed {
		load_t      load;
		logic       clear_block;
		logic       init_hash;
		logic       start_comp;
		logic       round;
		logic [5:0] round_idx;
		logic       update_hash;
		logic [2:0] out_idx;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       block_full;
		logic       pos_ge56;
	} dp_stat_t;

	localparam logic [7:0] PadByte = 8'h80;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage
`default_nettype wire

// ----- hdl/sha256_hash_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hash_engine
// sha-256 over a byte stream, digest out as eight 32-bit words
// ----------------------------------------------------------------------------
// input beats carry one byte (s_tdata), a byte-present flag (s_tuser) and
// s_tlast to end the message. s_tready is high only while the engine idles.
// the beat that takes the 64th byte of a block starts a compression: a load
// step, 64 rounds at one per cycle and a step to fold into the hash, with
// s_tready low throughout. a last beat pads the block (a step for 0x80, one
// for the length) and runs the final compression; the first digest word is
// valid after it, or after one more block when the padding or the last byte
// needs one. the digest leaves as eight beats on the m_ group, word 0 first,
// m_tlast on word 7, one per cycle while m_tready is high. a stalled m_tready
// holds the current word, and no input is taken until word 7 is gone. reset
// returns to the initial hash with an empty buffer.
// ----------------------------------------------------------------------------
module sha256_hash_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // data_byte
	input  wire         s_tuser,  // byte_valid
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast
);

	sha256_pkg::dp_cmd_t  cmd;
	sha256_pkg::dp_stat_t stat;
	logic [31:0] digest_word;
	logic [2:0]  out_idx;

	sha256_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_byte_valid(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.out_idx(out_idx), .stat(stat), .cmd(cmd)
	);

	sha256_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(s_tdata),
		.stat(stat), .digest_word(digest_word)
	);

	assign m_tdata = {5'd0, out_idx, digest_word};
	assign m_tlast = (out_idx == 3'd7);

endmodule
`default_nettype wire

// ----- hdl/sha256_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_datapath
// block buffer, length count, message schedule, round logic and hash state
// ----------------------------------------------------------------------------
module sha256_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  sha256_pkg::dp_cmd_t  cmd,
	input  wire  [7:0]           data_byte,
	output sha256_pkg::dp_stat_t stat,
	output logic [31:0]          digest_word
);

	// block held as 16 big-endian words, byte 0 in bits 31:24 of word 0
	logic [31:0] blk_q [16];
	logic [5:0]  pos_q;
	logic [60:0] total_q;
	logic [31:0] hash_q [8];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

	logic [63:0] bit_len;
	logic [31:0] w_new, w_cur, s0, s1, t1, t2;

	assign bit_len = {total_q, 3'b000};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// schedule: w_q[0] is the word for the current round
	always_comb begin
		s0    = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = w_q[0];
		t1 = h_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25)) +
			((e_q & f_q) ^ (~e_q & g_q)) + sha256_pkg::RoundConst[cmd.round_idx] + w_cur;
		t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22)) +
			((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			total_q <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
		end else begin
			unique case (cmd.load)
				sha256_pkg::LD_BYTE: begin
					blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= data_byte;
					pos_q   <= pos_q + 6'd1;
					total_q <= total_q + 61'd1;
				end
				sha256_pkg::LD_PAD80:
					blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= sha256_pkg::PadByte;
				sha256_pkg::LD_LENGTH: begin
					blk_q[14] <= bit_len[63:32];
					blk_q[15] <= bit_len[31:0];
				end
				default: ;
			endcase
			if (cmd.clear_block)
				for (int i = 0; i < 16; i++) blk_q[i] <= '0;
			if (cmd.update_hash) begin
				hash_q[0] <= hash_q[0] + a_q;
				hash_q[1] <= hash_q[1] + b_q;
				hash_q[2] <= hash_q[2] + c_q;
				hash_q[3] <= hash_q[3] + d_q;
				hash_q[4] <= hash_q[4] + e_q;
				hash_q[5] <= hash_q[5] + f_q;
				hash_q[6] <= hash_q[6] + g_q;
				hash_q[7] <= hash_q[7] + h_q;
			end
			if (cmd.init_hash) begin
				for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
				pos_q   <= '0;
				total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_comp) begin
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk_q[i];
			a_q <= hash_q[0]; b_q <= hash_q[1]; c_q <= hash_q[2]; d_q <= hash_q[3];
			e_q <= hash_q[4]; f_q <= hash_q[5]; g_q <= hash_q[6]; h_q <= hash_q[7];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
			h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

	// block_full: the next byte takes the last slot of the block
	assign stat = '{block_full: (pos_q == 6'd63), pos_ge56: (pos_q >= 6'd56)};
	assign digest_word = hash_q[cmd.out_idx];

endmodule
`default_nettype wire

// ----- hdl/sha256_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_ctrl
// sequences byte loads, 64 rounds per block, padding and digest output
// ----------------------------------------------------------------------------
module sha256_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire                  s_byte_valid,
	input  wire                  s_tlast,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [2:0]           out_idx,
	input  sha256_pkg::dp_stat_t stat,
	output sha256_pkg::dp_cmd_t  cmd
);

	sha256_pkg::state_t state_q, state_d;
	logic [5:0] rnd_q;
	logic [2:0] idx_q;
	logic       fin_q, pad80_done_q, len_done_q;
	logic       acc, done;

	assign acc  = s_tvalid && s_tready;
	assign done = (state_q == sha256_pkg::ST_EMIT) && m_tready && (idx_q == 3'd7);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE:
				if (acc) begin
					if (s_byte_valid && stat.block_full) state_d = sha256_pkg::ST_LOAD;
					else if (s_tlast) state_d = sha256_pkg::ST_PAD;
				end
			sha256_pkg::ST_LOAD:
				state_d = sha256_pkg::ST_ROUND;
			sha256_pkg::ST_ROUND:
				if (rnd_q == 6'd63) state_d = sha256_pkg::ST_UPDATE;
			sha256_pkg::ST_UPDATE:
				if (len_done_q) state_d = sha256_pkg::ST_EMIT;
				else if (fin_q)
					state_d = pad80_done_q ? sha256_pkg::ST_LEN : sha256_pkg::ST_PAD;
				else state_d = sha256_pkg::ST_IDLE;
			// 0x80 at 56 or later leaves no room for the length
			sha256_pkg::ST_PAD:
				state_d = stat.pos_ge56 ? sha256_pkg::ST_LOAD : sha256_pkg::ST_LEN;
			sha256_pkg::ST_LEN:
				state_d = sha256_pkg::ST_LOAD;
			sha256_pkg::ST_EMIT:
				if (done) state_d = sha256_pkg::ST_IDLE;
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load      = sha256_pkg::LD_NONE;
		cmd.round_idx = rnd_q;
		cmd.out_idx   = idx_q;
		s_tready = (state_q == sha256_pkg::ST_IDLE);
		m_tvalid = (state_q == sha256_pkg::ST_EMIT);
		out_idx  = idx_q;
		unique case (state_q)
			sha256_pkg::ST_IDLE:
				if (s_tvalid && s_byte_valid) cmd.load = sha256_pkg::LD_BYTE;
			sha256_pkg::ST_LOAD:
				cmd.start_comp = 1'b1;
			sha256_pkg::ST_ROUND:
				cmd.round = 1'b1;
			sha256_pkg::ST_UPDATE: begin
				cmd.update_hash = 1'b1;
				cmd.clear_block = 1'b1;
			end
			sha256_pkg::ST_PAD:
				cmd.load = sha256_pkg::LD_PAD80;
			sha256_pkg::ST_LEN:
				cmd.load = sha256_pkg::LD_LENGTH;
			sha256_pkg::ST_EMIT:
				cmd.init_hash = done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sha256_pkg::ST_IDLE;
			rnd_q        <= '0;
			idx_q        <= '0;
			fin_q        <= 1'b0;
			pad80_done_q <= 1'b0;
			len_done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sha256_pkg::ST_ROUND) rnd_q <= rnd_q + 6'd1;
			else rnd_q <= '0;
			if (state_q == sha256_pkg::ST_EMIT && m_tready) idx_q <= idx_q + 3'd1;
			if (done) begin
				fin_q        <= 1'b0;
				pad80_done_q <= 1'b0;
				len_done_q   <= 1'b0;
			end else begin
				if (acc && s_tlast) fin_q <= 1'b1;
				if (state_q == sha256_pkg::ST_PAD) pad80_done_q <= 1'b1;
				if (state_q == sha256_pkg::ST_LEN) len_done_q <= 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input taken during output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_ROUND && rnd_q == 6'd63) |=>
		state_q == sha256_pkg::ST_UPDATE) else $error("round count slip");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sha256_pkg::ST_EMIT && !m_tready) |=> (m_tvalid && $stable(idx_q)))
		else $error("word index moved while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (idx_q == 3'd0)) else $error("digest index not rewound");

endmodule
`default_nettype wire
